// ===== rtl/wsm_pkg.sv =====
// ----------------------------------------------------------------------------
// wsm_pkg: shared types and constants of the wheel speed median meter
// Holds the register map, the command that drives the window cells, the
// arithmetic constants and the width of the shared divider.
// ----------------------------------------------------------------------------
package wsm_pkg;

	// Default depth of the median window.
	localparam int WINDOW_DEPTH_DEF = 10;

	// Register indexes of the configuration channel.
	localparam logic [2:0] REG_DEBOUNCE = 3'd0;
	localparam logic [2:0] REG_TIMEOUT  = 3'd1;
	localparam logic [2:0] REG_CIRCUMF  = 3'd2;
	localparam logic [2:0] REG_STRIP    = 3'd3;
	localparam logic [2:0] REG_MIN_DUR  = 3'd4;
	localparam logic [2:0] REG_MAX_DUR  = 3'd5;

	// Register reset values.
	localparam logic [7:0]  DEBOUNCE_RST = 8'd40;
	localparam logic [15:0] TIMEOUT_RST  = 16'd10000;
	localparam logic [11:0] CIRCUMF_RST  = 12'd1276;
	localparam logic [7:0]  STRIP_RST    = 8'd55;
	localparam logic [15:0] MIN_DUR_RST  = 16'd400;
	localparam logic [15:0] MAX_DUR_RST  = 16'd10000;

	// Divider width: covers the duration numerator and denominator.
	localparam int DIV_W = 43;

	// Arithmetic constants (milli cm/s per km/h, mm per m, duration scale).
	localparam logic [DIV_W-1:0] CMS_PER_KMH_MILLI = 43'd27778;
	localparam logic [DIV_W-1:0] MM_PER_M = 43'd1000;
	localparam logic [DIV_W-1:0] STRIP_SCALE = 43'd16667000000;
	// Reciprocal of 16667/256 scaled by 2^37, rounded up. Multiplying a mm per
	// minute value below the saturation point by it and dropping 37 bits
	// gives the truncated Q8.8 speed exactly.
	localparam logic [30:0] SPEED_RECIP = 31'd2111020105;
	// Speed saturates at or above this mm per minute.
	localparam logic [27:0] SPEED_SAT_MPM = 28'd4266752;
	// Below this mm per minute the speed is under 0.01 km/h.
	localparam logic [27:0] SLOW_MPM = 28'd167;

	// Operations of the window cells.
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_CLEAR,
		OP_DEL,
		OP_INS,
		OP_ROT
	} cell_op_t;

	// Command broadcast to every cell of the window chain.
	typedef struct packed {
		cell_op_t    op;
		logic [15:0] value;
	} cell_cmd_t;

endpackage

// ===== rtl/wsm_cell.sv =====
// ----------------------------------------------------------------------------
// wsm_cell: one slot of the sorted median window
// Holds a value and its age. Neighbors pass data for deleting the oldest
// entry, inserting a new one in sorted place and rotating the row.
// ----------------------------------------------------------------------------
module wsm_cell #(
	parameter int DEPTH = wsm_pkg::WINDOW_DEPTH_DEF,
	parameter int AW    = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wsm_pkg::cell_cmd_t cmd,
	input  logic               left_valid,
	input  logic [15:0]        left_value,
	input  logic [AW-1:0]      left_age,
	input  logic               right_valid,
	input  logic [15:0]        right_value,
	input  logic [AW-1:0]      right_age,
	input  logic               shift_in,
	input  logic               gt_in,
	output logic               valid,
	output logic [15:0]        value,
	output logic [AW-1:0]      age,
	output logic               shift_out,
	output logic               gt_out
);
	import wsm_pkg::*;

	localparam logic [AW-1:0] OLDEST = AW'(DEPTH - 1);

	logic          valid_q;
	logic [15:0]   value_q;
	logic [AW-1:0] age_q;
	logic          valid_d;
	logic [15:0]   value_d;
	logic [AW-1:0] age_d;

	// The oldest entry leaves; everything above it moves down one slot.
	assign shift_out = shift_in | (valid_q && (age_q == OLDEST));
	// This slot and all above it hold values larger than the new one.
	assign gt_out = !valid_q || (value_q > cmd.value);

	// Next content of the slot.
	always_comb begin
		valid_d = valid_q;
		value_d = value_q;
		age_d   = age_q;
		case (cmd.op)
			OP_CLEAR: begin
				valid_d = 1'b0;
			end
			OP_DEL: begin
				if (shift_out) begin
					valid_d = right_valid;
					value_d = right_value;
					age_d   = right_age;
				end
			end
			OP_ROT: begin
				valid_d = right_valid;
				value_d = right_value;
				age_d   = right_age;
			end
			OP_INS: begin
				if (gt_in) begin
					valid_d = left_valid;
					value_d = left_value;
					age_d   = left_valid ? left_age + 1'b1 : left_age;
				end else if (gt_out) begin
					valid_d = 1'b1;
					value_d = cmd.value;
					age_d   = '0;
				end else begin
					age_d = valid_q ? age_q + 1'b1 : age_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Valid flag under reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// Payload of the slot.
	always_ff @(posedge clk) begin
		value_q <= value_d;
		age_q   <= age_d;
	end

	assign valid = valid_q;
	assign value = value_q;
	assign age   = age_q;

endmodule

// ===== rtl/wsm_divider.sv =====
// ----------------------------------------------------------------------------
// wsm_divider: shared restoring divider
// Produces one quotient bit per cycle while busy; after the last bit, done
// pulses with the quotient.
// ----------------------------------------------------------------------------
module wsm_divider #(
	parameter int W = wsm_pkg::DIV_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);
	import wsm_pkg::*;

	localparam int CNW = $clog2(W + 1);

	logic [W:0]     rem_q;
	logic [W-1:0]   quo_q;
	logic [W-1:0]   div_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [W:0]     rem_sh;
	logic           fits;

	// One restoring step: bring in the next dividend bit and try a subtract.
	assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
	assign fits   = rem_sh >= {1'b0, div_q};

	// Control under reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, div_q} : rem_sh;
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/wheel_speed_median_meter.sv =====
// ----------------------------------------------------------------------------
// wheel_speed_median_meter: wheel speed meter with a running median
// Debounces wheel pulses into a period, keeps a sorted median window of
// periods and reports median period, speed and animation duration.
// ----------------------------------------------------------------------------
// Usage: items arrive on s_* (s_tuser = 0 wheel pulse, 1 speed sample;
// s_tdata = timestamp in ms). A pulse leaves the block idle and gives no
// result. A sample gives one result on m_* (median, speed, duration).
// Registers are written on cfg_* at any time the block is idle; cfg_ready
// is always high and indexes above five are ignored.
// A sample passes the cell row to delete the oldest and insert the new
// period, rotates the row to read the middle entries, forms the median,
// runs a divider pass for mm per minute, a reciprocal multiply for the
// speed and a second divider pass for the duration. A median of zero or
// at or past the timeout finishes after the median step, a too slow speed
// skips the second pass, and a sample that times out clears the window
// and goes straight to its result. One sample is worked on at a time.
// After reset the window is empty and the registers hold their defaults.
// A result that m_tready does not take stays in the output register; the
// next sample may be taken meanwhile and waits finished until it drains.
// ----------------------------------------------------------------------------
module wheel_speed_median_meter #(
	parameter int WINDOW_DEPTH = wsm_pkg::WINDOW_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] time_ms
	input  logic        s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [15:0] median_period_ms, [31:16] speed_q8,
	                               // [47:32] duration_ms
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import wsm_pkg::*;

	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DEL  = 4'd1;
	localparam logic [3:0] ST_INS  = 4'd2;
	localparam logic [3:0] ST_ROT  = 4'd3;
	localparam logic [3:0] ST_MED  = 4'd4;
	localparam logic [3:0] ST_DIV1 = 4'd5;
	localparam logic [3:0] ST_DIV2 = 4'd6;
	localparam logic [3:0] ST_DIV3 = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [7:0]  debounce_q;
	logic [15:0] timeout_q;
	logic [11:0] circumf_q;
	logic [7:0]  strip_q;
	logic [15:0] min_dur_q;
	logic [15:0] max_dur_q;

	logic [3:0]    state_q;
	logic [31:0]   last_pulse_q;
	logic [15:0]   period_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rot_q;
	logic [15:0]   lo_q;
	logic [15:0]   hi_q;
	logic [15:0]   median_q;
	logic [27:0]   mpm_q;
	logic [15:0]   speed_q;
	logic [15:0]   dur_q;
	logic          launched_q;
	logic          out_valid_q;
	logic [47:0]   out_data_q;

	logic          in_xfer;
	logic [31:0]   gap;
	logic          timed_out;
	logic [CW-1:0] half;
	logic [16:0]   mid_sum;
	logic [15:0]   med_val;
	logic [58:0]   spd_prod;
	cell_cmd_t     cmd;

	logic             div_start;
	logic [DIV_W-1:0] div_dividend;
	logic [DIV_W-1:0] div_divisor;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;

	logic          cv   [WINDOW_DEPTH];
	logic [15:0]   cval [WINDOW_DEPTH];
	logic [AW-1:0] cage [WINDOW_DEPTH];
	logic          sh   [WINDOW_DEPTH+1];
	logic          gt   [WINDOW_DEPTH+1];
	logic          top_valid;
	logic [15:0]   top_value;
	logic [AW-1:0] top_age;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid && s_tready;
	assign gap       = s_tdata - last_pulse_q;
	assign timed_out = gap > {16'd0, timeout_q};
	assign half      = count_q >> 1;

	// Median from the captured middle entries.
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign med_val = count_q[0] ? hi_q : mid_sum[16:1];

	// Speed by reciprocal multiplication of the mm per minute value.
	assign spd_prod = {31'd0, mpm_q} * {28'd0, SPEED_RECIP};

	// Command for the cell row.
	always_comb begin
		cmd.value = period_q;
		case (state_q)
			ST_IDLE: cmd.op = (in_xfer && s_tuser && timed_out) ? OP_CLEAR : OP_HOLD;
			ST_DEL:  cmd.op = OP_DEL;
			ST_INS:  cmd.op = OP_INS;
			ST_ROT:  cmd.op = OP_ROT;
			default: cmd.op = OP_HOLD;
		endcase
	end

	// The top slot sees the bottom one while rotating, an empty slot else.
	assign top_valid = (state_q == ST_ROT) ? cv[0] : 1'b0;
	assign top_value = (state_q == ST_ROT) ? cval[0] : 16'd0;
	assign top_age   = (state_q == ST_ROT) ? cage[0] : '0;
	assign sh[0] = 1'b0;
	assign gt[0] = 1'b0;

	// Row of window cells, kept sorted from slot zero upward.
	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		logic          lv;
		logic [15:0]   lval;
		logic [AW-1:0] lage;
		logic          rv;
		logic [15:0]   rval;
		logic [AW-1:0] rage;
		if (i == 0) begin : g_first
			assign lv   = 1'b0;
			assign lval = 16'd0;
			assign lage = '0;
		end else begin : g_inner_l
			assign lv   = cv[i-1];
			assign lval = cval[i-1];
			assign lage = cage[i-1];
		end
		if (i == WINDOW_DEPTH - 1) begin : g_last
			assign rv   = top_valid;
			assign rval = top_value;
			assign rage = top_age;
		end else begin : g_inner_r
			assign rv   = cv[i+1];
			assign rval = cval[i+1];
			assign rage = cage[i+1];
		end
		wsm_cell #(
			.DEPTH(WINDOW_DEPTH),
			.AW   (AW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_valid (lv),
			.left_value (lval),
			.left_age   (lage),
			.right_valid(rv),
			.right_value(rval),
			.right_age  (rage),
			.shift_in   (sh[i]),
			.gt_in      (gt[i]),
			.valid      (cv[i]),
			.value      (cval[i]),
			.age        (cage[i]),
			.shift_out  (sh[i+1]),
			.gt_out     (gt[i+1])
		);
	end

	// Operands of the shared divider.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIV_W'(circumf_q) * MM_PER_M;
		div_divisor  = DIV_W'(median_q);
		case (state_q)
			ST_DIV1: begin
				div_start = !launched_q;
			end
			ST_DIV3: begin
				div_start    = !launched_q && (mpm_q >= SLOW_MPM);
				div_dividend = DIV_W'(strip_q) * STRIP_SCALE;
				div_divisor  = DIV_W'(mpm_q) * CMS_PER_KMH_MILLI;
			end
			default: begin
			end
		endcase
	end

	wsm_divider #(
		.W(DIV_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quo)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			timeout_q  <= TIMEOUT_RST;
			circumf_q  <= CIRCUMF_RST;
			strip_q    <= STRIP_RST;
			min_dur_q  <= MIN_DUR_RST;
			max_dur_q  <= MAX_DUR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data[7:0];
				REG_TIMEOUT:  timeout_q  <= cfg_data;
				REG_CIRCUMF:  circumf_q  <= cfg_data[11:0];
				REG_STRIP:    strip_q    <= cfg_data[7:0];
				REG_MIN_DUR:  min_dur_q  <= cfg_data;
				REG_MAX_DUR:  max_dur_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer and pulse state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_pulse_q <= '0;
			period_q     <= '0;
			count_q      <= '0;
			rot_q        <= '0;
			launched_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (!s_tuser) begin
							if (gap > {24'd0, debounce_q}) begin
								period_q <= (gap > 32'hFFFF) ? 16'hFFFF : gap[15:0];
							end
							last_pulse_q <= s_tdata;
						end else if (timed_out) begin
							count_q <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_DEL;
						end
					end
				end
				ST_DEL: begin
					state_q <= ST_INS;
				end
				ST_INS: begin
					if (count_q != CW'(WINDOW_DEPTH)) begin
						count_q <= count_q + 1'b1;
					end
					rot_q   <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					rot_q <= rot_q + 1'b1;
					if (rot_q == CW'(WINDOW_DEPTH - 1)) begin
						state_q <= ST_MED;
					end
				end
				ST_MED: begin
					if (med_val != 16'd0 && med_val < timeout_q) begin
						state_q <= ST_DIV1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV1: begin
					if (div_start) begin
						launched_q <= 1'b1;
					end else if (div_done) begin
						launched_q <= 1'b0;
						state_q    <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					state_q <= ST_DIV3;
				end
				ST_DIV3: begin
					if (div_start) begin
						launched_q <= 1'b1;
					end else if (!launched_q || div_done) begin
						launched_q <= 1'b0;
						state_q    <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				// A timed-out sample reports an empty window.
				median_q <= '0;
				speed_q  <= '0;
				dur_q    <= max_dur_q;
			end
			ST_ROT: begin
				// Slot zero holds the entry of rank rot_q.
				if (rot_q == half) begin
					hi_q <= cval[0];
				end
				if ((CW + 1)'(rot_q) + 1'b1 == {1'b0, half}) begin
					lo_q <= cval[0];
				end
			end
			ST_MED: begin
				median_q <= med_val;
				speed_q  <= '0;
				dur_q    <= max_dur_q;
			end
			ST_DIV1: begin
				if (div_done) begin
					mpm_q <= 28'(28'(div_quo[21:0]) * 28'd60);
				end
			end
			ST_DIV2: begin
				if (mpm_q < SPEED_SAT_MPM) begin
					speed_q <= spd_prod[52:37];
				end else begin
					speed_q <= 16'hFFFF;
				end
			end
			ST_DIV3: begin
				if (div_done) begin
					if (div_quo < DIV_W'(min_dur_q)) begin
						dur_q <= min_dur_q;
					end else if (div_quo > DIV_W'(max_dur_q)) begin
						dur_q <= max_dur_q;
					end else begin
						dur_q <= div_quo[15:0];
					end
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_data_q <= {dur_q, speed_q, median_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
